/* hdl/btq_pkg.sv */
// ----------------------------------------------------------------------------
// btq_pkg
// Shared types and constants of the bulk ticket queue: field widths, the
// operation and result kind codes, and the controller/datapath buses.
// ----------------------------------------------------------------------------
package btq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 8;
    localparam int KIND_W   = 2;
    localparam int LEVEL_W  = 5;
    localparam int TICKET_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_REPORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic accept;
        logic push_write;
        logic push_finish;
        logic pop_apply;
        logic rpt_first;
        logic rpt_next;
        logic rpt_empty;
    } btq_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic full;
        logic fill_zero;
        logic rpt_last;
        logic out_free;
    } btq_status_t;

endpackage

/* hdl/btq_req_if.sv */
// ----------------------------------------------------------------------------
// btq_req_if
// Request channel of the bulk ticket queue: an operation and a count.
// ----------------------------------------------------------------------------
interface btq_req_if import btq_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output operation, output count, input ready);
    modport sink   (input valid, input operation, input count, output ready);

endinterface

/* hdl/btq_res_if.sv */
// ----------------------------------------------------------------------------
// btq_res_if
// Result channel of the bulk ticket queue: status and report entries.
// ----------------------------------------------------------------------------
interface btq_res_if import btq_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic                error;
    logic [LEVEL_W-1:0]  level;
    logic [TICKET_W-1:0] ticket;
    logic                last;

    modport source (output valid, output kind, output error, output level,
                    output ticket, output last, input ready);
    modport sink   (input valid, input kind, input error, input level,
                    input ticket, input last, output ready);

endinterface

/* hdl/bulk_ticket_queue.sv */
// One request is taken at a time. A push writes the tickets that fit through the single write
// port of the ticket store, one ticket per cycle, and then gives its status; a pop gives its
// status; a report gives one entry per stored ticket, read through the single read port, or
// one empty entry. An untaken result stalls the push status, the pop and each report entry.
// Reset: head, fill level and ticket counter clear at once.
// ----------------------------------------------------------------------------
// bulk_ticket_queue
// Bounded FIFO of ticket numbers with bulk push, bulk pop and level report,
// built from a controller and a ring-buffer datapath.
// ----------------------------------------------------------------------------
module bulk_ticket_queue import btq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    btq_req_if.sink    request,
    btq_res_if.source  result
);

    btq_cmd_t    cmd;
    btq_status_t status;

    btq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_op    (request.operation),
        .req_ready (request.ready),
        .status    (status),
        .cmd       (cmd)
    );

    btq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_count (request.count),
        .result    (result)
    );

endmodule

/* hdl/btq_ctrl.sv */
// ----------------------------------------------------------------------------
// btq_ctrl
// Controller of the bulk ticket queue. Sequences one request at a time and
// drives the datapath through the command bus.
// ----------------------------------------------------------------------------
module btq_ctrl import btq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [OP_W-1:0]     req_op,
    output logic                req_ready,
    input  btq_status_t         status,
    output btq_cmd_t            cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_RPT_START,
        S_RPT_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (req_op)
                        OP_PUSH:   state_next = S_PUSH;
                        OP_POP:    state_next = S_POP;
                        OP_REPORT: state_next = S_RPT_START;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_PUSH:
            begin
                if (status.rem_zero || status.full)
                begin
                    if (status.out_free)
                    begin
                        cmd.push_finish = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.push_write = 1'b1;
                end
            end
            S_POP:
            begin
                if (status.out_free)
                begin
                    cmd.pop_apply = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RPT_START:
            begin
                if (status.fill_zero)
                begin
                    if (status.out_free)
                    begin
                        cmd.rpt_empty = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rpt_first = 1'b1;
                    state_next    = S_RPT_EMIT;
                end
            end
            S_RPT_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.rpt_next = 1'b1;
                    if (status.rpt_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A ticket is written only while there is room and tickets remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |-> (!status.full && !status.rem_zero))
        else $error("push write issued with a full queue or no tickets left");

    // A result is produced only when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_finish || cmd.pop_apply || cmd.rpt_empty || cmd.rpt_next)
        |-> status.out_free)
        else $error("result produced while the output register is occupied");

    // The final report entry returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rpt_next && status.rpt_last) |=> req_ready)
        else $error("controller not idle after the final report entry");

endmodule

/* hdl/btq_dp.sv */
// ----------------------------------------------------------------------------
// btq_dp
// Datapath of the bulk ticket queue: the ticket ring store, head and tail
// pointers, fill level, ticket counter, report read pointer and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module btq_dp import btq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  btq_cmd_t           cmd,
    output btq_status_t        status,
    input  logic [COUNT_W-1:0] req_count,
    btq_res_if.source          result
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;
    localparam int SW = $clog2(2 * QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_MAX = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

    logic [TICKET_W-1:0] store [QUEUE_DEPTH];

    logic [PW-1:0]       head_reg;
    logic [PW-1:0]       tail_reg;
    logic [FW-1:0]       fill_reg;
    logic [TICKET_W-1:0] next_ticket_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [FW-1:0]       idx_reg;
    logic [TICKET_W-1:0] rd_data_reg;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic                out_error_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [TICKET_W-1:0] out_ticket_reg;
    logic                out_last_reg;

    logic                underflow;
    logic [SW-1:0]       pop_sum;
    logic [PW-1:0]       pop_head;
    logic [FW-1:0]       pop_fill;
    logic                push_err;
    logic                rd_en;
    logic [PW-1:0]       rd_addr;
    logic [SW-1:0]       tail_sum;
    logic [PW-1:0]       tail_expect;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        logic [PW-1:0] res;
        if (ptr == PTR_MAX)
        begin
            res = '0;
        end
        else
        begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign status.rem_zero  = (rem_reg == '0);
    assign status.full      = (fill_reg == FILL_MAX);
    assign status.fill_zero = (fill_reg == '0);
    assign status.rpt_last  = (idx_reg == fill_reg);
    assign status.out_free  = !out_valid_reg || result.ready;

    assign push_err  = status.full && !status.rem_zero;
    assign underflow = (CW'(fill_reg) < CW'(rem_reg));

    always_comb
    begin
        pop_sum = SW'(head_reg) + SW'(rem_reg);
        if (pop_sum >= DEPTH_S)
        begin
            pop_sum = pop_sum - DEPTH_S;
        end
        pop_head = PW'(pop_sum);
        pop_fill = fill_reg - FW'(rem_reg);
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = rd_ptr_reg;
        if (cmd.rpt_first)
        begin
            rd_en   = 1'b1;
            rd_addr = head_reg;
        end
        else if (cmd.rpt_next && !status.rpt_last)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_write)
        begin
            store[tail_reg] <= next_ticket_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            next_ticket_reg <= '0;
            rem_reg         <= '0;
            rd_ptr_reg      <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                rem_reg <= req_count;
            end
            if (cmd.push_write)
            begin
                next_ticket_reg <= next_ticket_reg + 1'b1;
                tail_reg        <= ptr_inc(tail_reg);
                fill_reg        <= fill_reg + 1'b1;
                rem_reg         <= rem_reg - 1'b1;
            end
            if (cmd.push_finish)
            begin
                next_ticket_reg <= next_ticket_reg + TICKET_W'(rem_reg);
            end
            if (cmd.pop_apply)
            begin
                if (underflow)
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                    fill_reg <= '0;
                end
                else
                begin
                    head_reg <= pop_head;
                    fill_reg <= pop_fill;
                end
            end
            if (cmd.rpt_first)
            begin
                rd_ptr_reg <= ptr_inc(head_reg);
                idx_reg    <= FW'(1);
            end
            else if (cmd.rpt_next && !status.rpt_last)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                idx_reg    <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_finish || cmd.pop_apply || cmd.rpt_empty || cmd.rpt_next)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_finish)
        begin
            out_kind_reg   <= KIND_PUSH;
            out_error_reg  <= push_err;
            out_level_reg  <= LEVEL_W'(fill_reg);
            out_ticket_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.pop_apply)
        begin
            out_kind_reg   <= KIND_POP;
            out_error_reg  <= underflow;
            out_level_reg  <= underflow ? '0 : LEVEL_W'(pop_fill);
            out_ticket_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.rpt_empty)
        begin
            out_kind_reg   <= KIND_REPORT;
            out_error_reg  <= 1'b0;
            out_level_reg  <= '0;
            out_ticket_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.rpt_next)
        begin
            out_kind_reg   <= KIND_REPORT;
            out_error_reg  <= 1'b0;
            out_level_reg  <= LEVEL_W'(fill_reg);
            out_ticket_reg <= rd_data_reg;
            out_last_reg   <= status.rpt_last;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.kind   = out_kind_reg;
    assign result.error  = out_error_reg;
    assign result.level  = out_level_reg;
    assign result.ticket = out_ticket_reg;
    assign result.last   = out_last_reg;

    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(fill_reg);
        if (tail_sum >= DEPTH_S)
        begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail_expect = PW'(tail_sum);
    end

    // The fill level never exceeds the depth of the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill level beyond queue depth");

    // The tail always sits the fill level past the head, around the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == tail_expect)
        else $error("tail pointer out of step with head and fill level");

    // Each stored ticket advances the running counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |=> (next_ticket_reg == $past(next_ticket_reg) + 1'b1))
        else $error("ticket counter did not advance on a write");

endmodule
